FILE: hdl/ftip_pkg.sv
// ----------------------------------------------------------------------------
// ftip_pkg
// Shared types, widths, codes and helpers for the formant track interpolator.
// ----------------------------------------------------------------------------
package ftip_pkg;

   localparam int NUM_TRACKS_DEF = 19;
   localparam int MAX_TRACKS     = 32;

   localparam int VAL_W   = 24;
   localparam int TRK_W   = 5;
   localparam int STIME_W = 10;
   localparam int FT_W    = 8;
   localparam int WGT_W   = 9;
   localparam int TN_W    = 12;
   localparam int MUL_A_W = 26;
   localparam int PROD_W  = MUL_A_W + TN_W;
   localparam int ACC_W   = 40;
   localparam int DVD_W   = 36;
   localparam int DVS_W   = 10;
   localparam int QUO_W   = DVD_W + 1;
   localparam int FRAC_SH = 8;

   localparam logic [WGT_W-1:0] WGT_RESET = 9'd128;
   localparam logic [WGT_W-1:0] WGT_FULL  = 9'd256;

   localparam logic OP_INTERP = 1'b0;
   localparam logic OP_PRESET = 1'b1;

   localparam logic [2:0] MUL_RAMP = 3'd0;
   localparam logic [2:0] MUL_BL0  = 3'd1;
   localparam logic [2:0] MUL_BL1  = 3'd2;
   localparam logic [2:0] MUL_SM0  = 3'd3;
   localparam logic [2:0] MUL_SM1  = 3'd4;

   localparam logic DIV_RAMP  = 1'b0;
   localparam logic DIV_BLEND = 1'b1;

   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic       acc_clr;
      logic [2:0] mul_sel;
      logic       div_start;
      logic       div_sel;
      logic       ramp_sel;
      logic       r0_ld;
      logic       r1_ld;
      logic       blend_ld;
      logic       smooth_ld;
      logic       preset_ld;
      logic       zero_ld;
      logic       rsp_ld;
   } cmd_type;

   typedef struct packed {
      logic trk_ok;
      logic preset;
      logic overlap;
      logic div_busy;
   } status_type;

   function automatic logic signed [VAL_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] vmax;
      logic signed [ACC_W-1:0] vmin;
      vmax = ACC_W'(  (1 <<< (VAL_W-1)) - 1);
      vmin = -ACC_W'( 1 <<< (VAL_W-1));
      if (v > vmax) begin
         sat24 = vmax[VAL_W-1:0];
      end else if (v < vmin) begin
         sat24 = vmin[VAL_W-1:0];
      end else begin
         sat24 = v[VAL_W-1:0];
      end
   endfunction

endpackage

FILE: hdl/ftip_div.sv
// ----------------------------------------------------------------------------
// ftip_div
// Sequential signed-by-unsigned divider, truncating toward zero, 2 bits/cycle.
// ----------------------------------------------------------------------------
module ftip_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ftip_pkg::ACC_W-1:0]     dividend,
   input  logic        [ftip_pkg::DVS_W-1:0]     divisor,
   output logic                                  busy,
   output logic signed [ftip_pkg::QUO_W-1:0]     quotient
);

   localparam int STEPS = ftip_pkg::DVD_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                          busy_ff, busy_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          neg_ff, neg_in;
   logic [ftip_pkg::DVD_W-1:0]    quo_ff, quo_in;
   logic [ftip_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [ftip_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [ftip_pkg::ACC_W-1:0]    mag;
   logic [ftip_pkg::DVD_W-1:0]    q;
   logic [ftip_pkg::DVS_W:0]      r;

   assign mag = dividend[ftip_pkg::ACC_W-1] ? ftip_pkg::ACC_W'(-dividend)
                                           : ftip_pkg::ACC_W'(dividend);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q       = quo_ff;
      r       = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         neg_in  = dividend[ftip_pkg::ACC_W-1];
         quo_in  = mag[ftip_pkg::DVD_W-1:0];
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         r = {1'b0, rem_ff};
         for (int i = 0; i < 2; i++) begin
            r = {r[ftip_pkg::DVS_W-1:0], q[ftip_pkg::DVD_W-1]};
            q = {q[ftip_pkg::DVD_W-2:0], 1'b0};
            if (r >= {1'b0, dvs_ff}) begin
               r    = r - {1'b0, dvs_ff};
               q[0] = 1'b1;
            end
         end
         quo_in = q;
         rem_in = r[ftip_pkg::DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

FILE: hdl/ftip_dp.sv
// ----------------------------------------------------------------------------
// ftip_dp
// Datapath: captured item, ramp selection, multiply-accumulate, divider,
// per-track smoother state, weight register and result register.
// ----------------------------------------------------------------------------
module ftip_dp #(
   parameter int NUM_TRACKS = ftip_pkg::NUM_TRACKS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_operation,
   input  logic        [ftip_pkg::TRK_W-1:0]     req_track_index,
   input  logic        [ftip_pkg::STIME_W-1:0]   req_start_time,
   input  logic signed [ftip_pkg::VAL_W-1:0]     req_start_value,
   input  logic        [ftip_pkg::STIME_W-1:0]   req_end_time,
   input  logic signed [ftip_pkg::VAL_W-1:0]     req_end_value,
   input  logic signed [ftip_pkg::VAL_W-1:0]     req_mid_value,
   input  logic        [ftip_pkg::FT_W-1:0]      req_frame_time,
   input  logic        [ftip_pkg::FT_W-1:0]      req_duration,
   input  logic                                  csr_we,
   input  logic        [ftip_pkg::WGT_W-1:0]     csr_smoothing_weight,
   input  ftip_pkg::cmd_type                     cmd,
   output ftip_pkg::status_type                  status,
   output logic        [ftip_pkg::TRK_W-1:0]     rsp_result_track,
   output logic signed [ftip_pkg::VAL_W-1:0]     rsp_track_value
);

   localparam int IDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
   localparam int VW    = ftip_pkg::VAL_W;
   localparam int TW    = ftip_pkg::TN_W;

   logic                          op_ff;
   logic [ftip_pkg::TRK_W-1:0]    trk_ff;
   logic [ftip_pkg::STIME_W-1:0]  st_ff, et_ff;
   logic signed [VW-1:0]          sv_ff, ev_ff, mid_ff;
   logic [ftip_pkg::FT_W-1:0]     t_ff, d_ff;

   logic [ftip_pkg::WGT_W-1:0]    weight_ff, weight_in;
   logic signed [VW-1:0]          smoothed_ff [NUM_TRACKS];
   logic signed [VW-1:0]          r0_ff, r0_in, r1_ff, r1_in, res_ff, res_in;
   logic signed [ftip_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [ftip_pkg::TRK_W-1:0]    otrk_ff;
   logic signed [VW-1:0]          oval_ff;

   logic                          trk_ok;
   logic [IDX_W-1:0]              idx;
   logic signed [VW-1:0]          old_val;
   logic signed [TW-1:0]          steady, tt_s, u_s, d_minus_t;
   logic                          overlap, before_rise, in_steady;
   logic [ftip_pkg::STIME_W-1:0]  tt;
   logic signed [VW-1:0]          ra, rb;
   logic signed [TW-1:0]          tn;
   logic [ftip_pkg::STIME_W-1:0]  dn;
   logic signed [VW:0]            diff;
   logic signed [ftip_pkg::MUL_A_W-1:0] mul_a;
   logic signed [TW-1:0]          mul_b;
   logic signed [ftip_pkg::PROD_W-1:0]  prod;
   logic [ftip_pkg::WGT_W-1:0]    w_eff, w_rest;
   logic                          div_busy;
   logic signed [ftip_pkg::QUO_W-1:0]   quo;
   logic [ftip_pkg::DVS_W-1:0]    div_dvs;
   logic signed [VW-1:0]          ramp_res;
   logic signed [ftip_pkg::ACC_W-1:0]   quo_ext;

   assign trk_ok  = {1'b0, trk_ff} < (ftip_pkg::TRK_W+1)'(NUM_TRACKS);
   assign idx     = trk_ff[IDX_W-1:0];
   assign old_val = smoothed_ff[idx];

   assign steady      = $signed({4'b0, d_ff}) - $signed({2'b0, st_ff})
                        - $signed({2'b0, et_ff});
   assign overlap     = steady[TW-1];
   assign before_rise = {2'b0, t_ff} < st_ff;
   assign tt          = {2'b0, t_ff} - st_ff;
   assign tt_s        = $signed({2'b0, tt});
   assign in_steady   = tt_s <= steady;
   assign u_s         = tt_s - steady;
   assign d_minus_t   = $signed({4'b0, d_ff}) - $signed({4'b0, t_ff});

   always_comb begin
      ra = ev_ff;
      rb = mid_ff;
      tn = d_minus_t;
      dn = et_ff;
      if (!cmd.ramp_sel) begin
         if (overlap || before_rise) begin
            ra = sv_ff;
            rb = mid_ff;
            tn = $signed({4'b0, t_ff});
            dn = st_ff;
         end else if (in_steady) begin
            ra = mid_ff;
            rb = mid_ff;
            tn = '0;
            dn = ftip_pkg::STIME_W'(1);
         end else begin
            ra = mid_ff;
            rb = ev_ff;
            tn = u_s;
            dn = et_ff;
         end
      end
   end

   assign diff   = $signed({rb[VW-1], rb}) - $signed({ra[VW-1], ra});
   assign w_eff  = (weight_ff > ftip_pkg::WGT_FULL) ? ftip_pkg::WGT_FULL : weight_ff;
   assign w_rest = ftip_pkg::WGT_FULL - w_eff;

   always_comb begin
      case (cmd.mul_sel)
         ftip_pkg::MUL_RAMP: begin
            mul_a = {diff[VW], diff};
            mul_b = tn;
         end
         ftip_pkg::MUL_BL0: begin
            mul_a = {{2{r0_ff[VW-1]}}, r0_ff};
            mul_b = d_minus_t;
         end
         ftip_pkg::MUL_BL1: begin
            mul_a = {{2{r1_ff[VW-1]}}, r1_ff};
            mul_b = $signed({4'b0, t_ff});
         end
         ftip_pkg::MUL_SM0: begin
            mul_a = {{2{r0_ff[VW-1]}}, r0_ff};
            mul_b = $signed({3'b0, w_eff});
         end
         ftip_pkg::MUL_SM1: begin
            mul_a = {{2{old_val[VW-1]}}, old_val};
            mul_b = $signed({3'b0, w_rest});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.mul_en) begin
         acc_in = (cmd.acc_clr ? '0 : acc_ff) + {{2{prod[ftip_pkg::PROD_W-1]}}, prod};
      end
   end

   assign div_dvs = (cmd.div_sel == ftip_pkg::DIV_BLEND) ? {2'b0, d_ff} : dn;

   ftip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign quo_ext = {{3{quo[ftip_pkg::QUO_W-1]}}, quo};

   always_comb begin
      if (tn <= $signed(TW'(0))) begin
         ramp_res = ra;
      end else if (tn >= $signed({2'b0, dn})) begin
         ramp_res = rb;
      end else begin
         ramp_res = ra + quo[VW-1:0];
      end
   end

   always_comb begin
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      res_in    = res_ff;
      weight_in = csr_we ? csr_smoothing_weight : weight_ff;
      if (cmd.r0_ld) begin
         r0_in = ramp_res;
      end
      if (cmd.r1_ld) begin
         r1_in = ramp_res;
      end
      if (cmd.blend_ld) begin
         r0_in = (d_ff == '0) ? mid_ff : ftip_pkg::sat24(quo_ext);
      end
      if (cmd.smooth_ld) begin
         res_in = ftip_pkg::sat24(acc_ff >>> ftip_pkg::FRAC_SH);
      end
      if (cmd.preset_ld) begin
         res_in = mid_ff;
      end
      if (cmd.zero_ld) begin
         res_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= ftip_pkg::WGT_RESET;
         for (int i = 0; i < NUM_TRACKS; i++) begin
            smoothed_ff[i] <= '0;
         end
      end else begin
         weight_ff <= weight_in;
         if ((cmd.smooth_ld || cmd.preset_ld) && trk_ok) begin
            smoothed_ff[idx] <= res_in;
         end
      end
      if (cmd.capture) begin
         op_ff  <= req_operation;
         trk_ff <= req_track_index;
         st_ff  <= req_start_time;
         sv_ff  <= req_start_value;
         et_ff  <= req_end_time;
         ev_ff  <= req_end_value;
         mid_ff <= req_mid_value;
         t_ff   <= req_frame_time;
         d_ff   <= req_duration;
      end
      acc_ff <= acc_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      res_ff <= res_in;
      if (cmd.rsp_ld) begin
         otrk_ff <= trk_ff;
         oval_ff <= res_ff;
      end
   end

   assign status.trk_ok   = trk_ok;
   assign status.preset   = (op_ff == ftip_pkg::OP_PRESET);
   assign status.overlap  = overlap;
   assign status.div_busy = div_busy;

   assign rsp_result_track = otrk_ff;
   assign rsp_track_value  = oval_ff;

endmodule

FILE: hdl/ftip_ctrl.sv
// ----------------------------------------------------------------------------
// ftip_ctrl
// Sequencer: steps the datapath through ramps, blend (overlap only) and smoother per item;
// presets and out-of-range tracks load the result directly.
module ftip_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ftip_pkg::status_type status,
   output ftip_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_RMUL  = 4'd2;
   localparam logic [3:0] S_RDIVS = 4'd3;
   localparam logic [3:0] S_RDIVW = 4'd4;
   localparam logic [3:0] S_RFIN  = 4'd5;
   localparam logic [3:0] S_BMUL0 = 4'd6;
   localparam logic [3:0] S_BMUL1 = 4'd7;
   localparam logic [3:0] S_BDIVS = 4'd8;
   localparam logic [3:0] S_BDIVW = 4'd9;
   localparam logic [3:0] S_BFIN  = 4'd10;
   localparam logic [3:0] S_SMUL0 = 4'd11;
   localparam logic [3:0] S_SMUL1 = 4'd12;
   localparam logic [3:0] S_SFIN  = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsel_ff, rsel_in;
   logic       rvalid_ff, rvalid_in;

   always_comb begin
      state_in     = state_ff;
      rsel_in      = rsel_ff;
      cmd          = '0;
      cmd.ramp_sel = rsel_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            rsel_in = 1'b0;
            if (!status.trk_ok) begin
               cmd.zero_ld = 1'b1;
               state_in    = S_DONE;
            end else if (status.preset) begin
               cmd.preset_ld = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_RMUL;
            end
         end
         S_RMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_clr = 1'b1;
            cmd.mul_sel = ftip_pkg::MUL_RAMP;
            state_in    = S_RDIVS;
         end
         S_RDIVS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = ftip_pkg::DIV_RAMP;
            state_in      = S_RDIVW;
         end
         S_RDIVW: begin
            if (!status.div_busy) begin
               state_in = S_RFIN;
            end
         end
         S_RFIN: begin
            if (!rsel_ff) begin
               cmd.r0_ld = 1'b1;
               if (status.overlap) begin
                  rsel_in  = 1'b1;
                  state_in = S_RMUL;
               end else begin
                  state_in = S_SMUL0;
               end
            end else begin
               cmd.r1_ld = 1'b1;
               state_in  = S_BMUL0;
            end
         end
         S_BMUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_clr = 1'b1;
            cmd.mul_sel = ftip_pkg::MUL_BL0;
            state_in    = S_BMUL1;
         end
         S_BMUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ftip_pkg::MUL_BL1;
            state_in    = S_BDIVS;
         end
         S_BDIVS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = ftip_pkg::DIV_BLEND;
            state_in      = S_BDIVW;
         end
         S_BDIVW: begin
            cmd.div_sel = ftip_pkg::DIV_BLEND;
            if (!status.div_busy) begin
               state_in = S_BFIN;
            end
         end
         S_BFIN: begin
            cmd.blend_ld = 1'b1;
            state_in     = S_SMUL0;
         end
         S_SMUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_clr = 1'b1;
            cmd.mul_sel = ftip_pkg::MUL_SM0;
            state_in    = S_SMUL1;
         end
         S_SMUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ftip_pkg::MUL_SM1;
            state_in    = S_SFIN;
         end
         S_SFIN: begin
            cmd.smooth_ld = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rvalid_ff || rsp_ready) begin
               cmd.rsp_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (cmd.rsp_ld) begin
         rvalid_in = 1'b1;
      end else if (rsp_ready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsel_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsel_ff   <= rsel_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_valid = rvalid_ff;

endmodule

FILE: hdl/formant_track_interpolator.sv
// Flow: one transaction at a time, next one accepted in the cycle after the result
// loads; the 2-bit-per-cycle divider (one or three divisions per item) sets it.
// Reset: synchronous; clears the controller, the weight to 128 and all track
// smoother values to zero.
// ----------------------------------------------------------------------------
// formant_track_interpolator
// Piecewise/blended parameter track interpolation with per-track smoothing.
// ----------------------------------------------------------------------------
module formant_track_interpolator #(
   parameter int NUM_TRACKS = ftip_pkg::NUM_TRACKS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic        [ftip_pkg::TRK_W-1:0]     req_track_index,
   input  logic        [ftip_pkg::STIME_W-1:0]   req_start_time,
   input  logic signed [ftip_pkg::VAL_W-1:0]     req_start_value,
   input  logic        [ftip_pkg::STIME_W-1:0]   req_end_time,
   input  logic signed [ftip_pkg::VAL_W-1:0]     req_end_value,
   input  logic signed [ftip_pkg::VAL_W-1:0]     req_mid_value,
   input  logic        [ftip_pkg::FT_W-1:0]      req_frame_time,
   input  logic        [ftip_pkg::FT_W-1:0]      req_duration,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [ftip_pkg::TRK_W-1:0]     rsp_result_track,
   output logic signed [ftip_pkg::VAL_W-1:0]     rsp_track_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [ftip_pkg::WGT_W-1:0]     csr_smoothing_weight
);

   ftip_pkg::cmd_type    cmd;
   ftip_pkg::status_type status;

   assign csr_ready = 1'b1;

   ftip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ftip_dp #(
      .NUM_TRACKS (NUM_TRACKS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_operation        (req_operation),
      .req_track_index      (req_track_index),
      .req_start_time       (req_start_time),
      .req_start_value      (req_start_value),
      .req_end_time         (req_end_time),
      .req_end_value        (req_end_value),
      .req_mid_value        (req_mid_value),
      .req_frame_time       (req_frame_time),
      .req_duration         (req_duration),
      .csr_we               (csr_valid & csr_ready),
      .csr_smoothing_weight (csr_smoothing_weight),
      .cmd                  (cmd),
      .status               (status),
      .rsp_result_track     (rsp_result_track),
      .rsp_track_value      (rsp_track_value)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new transaction accepted while one is in progress");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_ld |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

FILE: dv/tb_formant_track_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_formant_track_interpolator
// Drives track items through the interpolator with random gaps and stalls,
// predicts each smoothed track value and checks every response in order.
// ----------------------------------------------------------------------------
module tb_formant_track_interpolator;

   localparam int NTRK = ftip_pkg::NUM_TRACKS_DEF;

   typedef struct {
      logic                              op;
      logic [ftip_pkg::TRK_W-1:0]        trk;
      logic [ftip_pkg::STIME_W-1:0]      st;
      logic signed [ftip_pkg::VAL_W-1:0] sv;
      logic [ftip_pkg::STIME_W-1:0]      et;
      logic signed [ftip_pkg::VAL_W-1:0] ev;
      logic signed [ftip_pkg::VAL_W-1:0] mid;
      logic [ftip_pkg::FT_W-1:0]         ft;
      logic [ftip_pkg::FT_W-1:0]         dur;
      bit                                typed;
      logic signed [ftip_pkg::VAL_W-1:0] typed_val;
   } track_item_type;

   typedef struct {
      logic [ftip_pkg::TRK_W-1:0]        trk;
      logic signed [ftip_pkg::VAL_W-1:0] val;
   } track_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = ftip_pkg::OP_INTERP;
   logic [ftip_pkg::TRK_W-1:0] req_track_index = '0;
   logic [ftip_pkg::STIME_W-1:0] req_start_time = '0;
   logic signed [ftip_pkg::VAL_W-1:0] req_start_value = '0;
   logic [ftip_pkg::STIME_W-1:0] req_end_time = '0;
   logic signed [ftip_pkg::VAL_W-1:0] req_end_value = '0;
   logic signed [ftip_pkg::VAL_W-1:0] req_mid_value = '0;
   logic [ftip_pkg::FT_W-1:0] req_frame_time = '0;
   logic [ftip_pkg::FT_W-1:0] req_duration = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ftip_pkg::TRK_W-1:0] rsp_result_track;
   logic signed [ftip_pkg::VAL_W-1:0] rsp_track_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ftip_pkg::WGT_W-1:0] csr_smoothing_weight = '0;

   logic [ftip_pkg::WGT_W-1:0] weight_shadow;
   longint smoother_shadow [NTRK];
   track_rsp_type pending_values[$];
   int errors = 0;
   bit busy_sink = 1'b0;

   formant_track_interpolator dut (.*);

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   function automatic longint ramp_at(longint a, longint b, longint t, longint d);
      if (t <= 0) return a;
      if (t >= d) return b;
      return a + ((b - a) * t) / d;
   endfunction

   function automatic longint clip24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint shape_value(track_item_type it);
      longint st, et, t, d, steady, sp, ep;
      st = it.st; et = it.et; t = it.ft; d = it.dur;
      steady = d - (st + et);
      if (steady >= 0) begin
         if (t < st) return ramp_at(it.sv, it.mid, t, st);
         t = t - st;
         if (t <= steady) return it.mid;
         return ramp_at(it.mid, it.ev, t - steady, et);
      end
      sp = ramp_at(it.sv, it.mid, t, st);
      ep = ramp_at(it.ev, it.mid, d - t, et);
      if (d == 0) return it.mid;
      return clip24(((d - t) * sp + t * ep) / d);
   endfunction

   function automatic track_rsp_type smooth_track(track_item_type it);
      track_rsp_type r;
      longint w, v;
      r.trk = it.trk;
      r.val = '0;
      if (it.trk < NTRK) begin
         if (it.op == ftip_pkg::OP_PRESET) begin
            v = it.mid;
         end else begin
            w = (weight_shadow > ftip_pkg::WGT_FULL) ? 256 : weight_shadow;
            v = clip24((w * shape_value(it) + (256 - w) * smoother_shadow[it.trk]) >>> 8);
         end
         smoother_shadow[it.trk] = v;
         r.val = v[ftip_pkg::VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic int gap_len();
      if (busy_sink) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (busy_sink || $urandom_range(0, 2) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      track_rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            $error("unexpected response track %0d value %0d", rsp_result_track,
                   rsp_track_value);
            errors++;
         end else begin
            exp_rsp = pending_values.pop_front();
            if (rsp_result_track !== exp_rsp.trk) begin
               $error("result_track exp %0d got %0d", exp_rsp.trk, rsp_result_track);
               errors++;
            end
            if (rsp_track_value !== exp_rsp.val) begin
               $error("track_value exp %0d got %0d", exp_rsp.val, rsp_track_value);
               errors++;
            end
         end
      end
   end

   task automatic send_item(track_item_type it);
      track_rsp_type r;
      int gap;
      req_valid = 1'b1;
      req_operation = it.op;
      req_track_index = it.trk;
      req_start_time = it.st;
      req_start_value = it.sv;
      req_end_time = it.et;
      req_end_value = it.ev;
      req_mid_value = it.mid;
      req_frame_time = it.ft;
      req_duration = it.dur;
      do @(posedge clock); while (!req_ready);
      r = smooth_track(it);
      if (it.typed) r.val = it.typed_val;
      pending_values.push_back(r);
      @(negedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_weight(logic [ftip_pkg::WGT_W-1:0] w);
      req_valid = 1'b0;
      wait (pending_values.size() == 0);
      repeat (100) @(negedge clock);
      csr_valid = 1'b1;
      csr_smoothing_weight = w;
      do @(posedge clock); while (!csr_ready);
      weight_shadow = w;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic track_item_type row(logic op, int trk, int st, int sv, int et, int ev,
                                          int mid, int ft, int dur, bit typed = 0,
                                          int tv = 0);
      track_item_type it;
      it.op  = op;
      it.trk = ftip_pkg::TRK_W'(trk);
      it.st  = ftip_pkg::STIME_W'(st);
      it.sv  = ftip_pkg::VAL_W'(sv);
      it.et  = ftip_pkg::STIME_W'(et);
      it.ev  = ftip_pkg::VAL_W'(ev);
      it.mid = ftip_pkg::VAL_W'(mid);
      it.ft  = ftip_pkg::FT_W'(ft);
      it.dur = ftip_pkg::FT_W'(dur);
      it.typed = typed;
      it.typed_val = ftip_pkg::VAL_W'(tv);
      return it;
   endfunction

   function automatic logic signed [ftip_pkg::VAL_W-1:0] rand_val();
      if ($urandom_range(0, 2) == 0) return ftip_pkg::VAL_W'($urandom());
      return ftip_pkg::VAL_W'(int'($urandom_range(0, 20000)) - 10000);
   endfunction

   function automatic track_item_type rand_item();
      track_item_type it;
      it.typed = 0;
      it.typed_val = '0;
      it.op = ($urandom_range(0, 6) == 0) ? ftip_pkg::OP_PRESET : ftip_pkg::OP_INTERP;
      it.trk = ($urandom_range(0, 11) == 0) ? ftip_pkg::TRK_W'($urandom_range(NTRK, 31))
                                             : ftip_pkg::TRK_W'($urandom_range(0, NTRK - 1));
      it.dur = ($urandom_range(0, 40) == 0) ? '0 : ftip_pkg::FT_W'($urandom_range(1, 255));
      if ($urandom_range(0, 4) == 0) begin
         it.st = ftip_pkg::STIME_W'($urandom());
         it.et = ftip_pkg::STIME_W'($urandom());
      end else begin
         it.st = ftip_pkg::STIME_W'($urandom_range(0, it.dur / 2 + 4));
         it.et = ftip_pkg::STIME_W'($urandom_range(0, it.dur / 2 + 4));
      end
      it.ft = ($urandom_range(0, 5) == 0) ? ftip_pkg::FT_W'($urandom())
                                          : ftip_pkg::FT_W'($urandom_range(0, it.dur));
      it.sv = rand_val(); it.ev = rand_val(); it.mid = rand_val();
      return it;
   endfunction

   track_item_type directed_rows[$];
   logic [ftip_pkg::WGT_W-1:0] phase_weights[$];

   initial begin
      weight_shadow = ftip_pkg::WGT_RESET;
      foreach (smoother_shadow[i]) smoother_shadow[i] = 0;
      directed_rows = '{
         row(ftip_pkg::OP_PRESET, 0, 0, 0, 0, 0, 8388607, 0, 1, 1, 8388607),
         row(ftip_pkg::OP_PRESET, 1, 0, 0, 0, 0, -8388608, 0, 1, 1, -8388608),
         row(ftip_pkg::OP_INTERP, 31, 5, 100, 5, 200, 300, 3, 20, 1, 0),
         row(ftip_pkg::OP_PRESET, 19, 0, 0, 0, 0, 1234, 0, 1, 1, 0),
         row(ftip_pkg::OP_INTERP, 2, 0, 0, 0, 0, 0, 0, 1, 1, 0),
         row(ftip_pkg::OP_INTERP, 3, 4, 1000, 3, -2000, 5000, 2, 10, 0, 0),
         row(ftip_pkg::OP_INTERP, 3, 4, 1000, 3, -2000, 5000, 5, 10, 0, 0),
         row(ftip_pkg::OP_INTERP, 3, 4, 1000, 3, -2000, 5000, 9, 10, 0, 0),
         row(ftip_pkg::OP_INTERP, 3, 4, 1000, 3, -2000, 5000, 255, 10, 0, 0),
         row(ftip_pkg::OP_INTERP, 4, 0, 777, 0, -777, 4096, 0, 8, 0, 0),
         row(ftip_pkg::OP_INTERP, 4, 0, 777, 0, -777, 4096, 8, 8, 0, 0),
         row(ftip_pkg::OP_INTERP, 5, 1023, -8388608, 1023, 8388607, 0, 100, 255, 0, 0),
         row(ftip_pkg::OP_INTERP, 6, 3, 50, 4, 60, 70, 0, 0, 0, 0),
         row(ftip_pkg::OP_INTERP, 7, 1023, -8388608, 1023, 8388607, -8388608, 255, 1, 0, 0),
         row(ftip_pkg::OP_INTERP, 8, 1023, 8388607, 0, 0, 8388607, 255, 255, 0, 0),
         row(ftip_pkg::OP_INTERP, 9, 0, 10, 20, 30, 40, 4, 10, 0, 0),
         row(ftip_pkg::OP_INTERP, 10, 0, 0, 1023, -8388608, 8388607, 0, 255, 0, 0),
         row(ftip_pkg::OP_INTERP, 0, 0, 0, 0, 0, -8388608, 0, 255, 0, 0),
         row(ftip_pkg::OP_INTERP, 18, 2, -5, 2, 5, -1, 1, 4, 0, 0)
      };
      phase_weights = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd300,
                        ftip_pkg::WGT_W'($urandom_range(2, 255))};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i]) send_item(directed_rows[i]);
      foreach (phase_weights[p]) begin
         write_weight(phase_weights[p]);
         busy_sink = (p == 2);
         repeat (140) send_item(rand_item());
      end
      req_valid = 1'b0;
      wait (pending_values.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_values.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
